@@ sv/assert_macros.svh @@
// Assertion macros shared by the victim select RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ sv/wplru_pkg.sv @@
// Types and constants of the way-partitioned LRU victim select block.
package wplru_pkg;

   localparam int DEF_SETS = 2048;
   localparam int DEF_WAYS = 16;

   localparam int STAMP_W   = 64;
   localparam int OP_W      = 2;
   localparam int CPU_W     = 6;
   localparam int SET_W     = 11;
   localparam int WAY_W     = 4;
   localparam int MASK_W    = 16;
   localparam int G1_W      = 5;
   localparam int CPUCNT_W  = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   localparam logic [G1_W-1:0]     G1_RESET     = 5'd8;
   localparam logic [CPUCNT_W-1:0] CPUCNT_RESET = 7'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUP1_WAYS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_COUNT   = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_FIND   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_FILL   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_TREE,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic reduce;
      logic update;
      logic clear;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_status_type;

endpackage

@@ sv/wplru_dp.sv @@
// Datapath: config registers, stamp memory, range logic, min tree and stamp counter.
`include "assert_macros.svh"

module wplru_dp import wplru_pkg::*; #(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [CPU_W-1:0]     req_cpu,
   input  logic [SET_W-1:0]     req_set_index,
   input  logic [WAY_W-1:0]     req_way,
   input  logic [MASK_W-1:0]    req_valid_mask,
   input  logic                 req_is_write,
   input  logic                 req_hit,
   input  logic                 csr_wr,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output logic [WAY_W-1:0]     rsp_victim_way,
   output logic                 rsp_victim_was_invalid
);

   localparam int AW     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int LEVELS = $clog2(WAYS);
   localparam int NP     = 1 << LEVELS;
   localparam logic [5:0] WAYS_V = 6'(WAYS);

   logic [G1_W-1:0]     group1_ff;
   logic [CPUCNT_W-1:0] cpu_count_ff;

   logic [OP_W-1:0]   op_ff;
   logic [CPU_W-1:0]  cpu_ff;
   logic [MASK_W-1:0] mask_ff;
   logic              hit_ff;
   logic              is_write_ff;
   logic [AW-1:0]     addr_ff;
   logic              set_ok_ff;
   logic [LEVELS-1:0] way_idx_ff;
   logic              way_ok_ff;

   logic [STAMP_W-1:0] stamp_mem_ff [SETS][WAYS];
   logic [STAMP_W-1:0] counter_ff;
   logic [STAMP_W-1:0] counter_in;
   logic [AW-1:0]      clr_addr_ff;
   logic [AW-1:0]      clr_addr_in;

   logic [STAMP_W-1:0] node_stamp_ff [NP];
   logic               node_live_ff  [NP];
   logic [LEVELS-1:0]  node_way_ff   [NP];
   logic [STAMP_W-1:0] red_stamp [NP/2];
   logic               red_live  [NP/2];
   logic [LEVELS-1:0]  red_way   [NP/2];

   logic              inv_found_ff;
   logic [LEVELS-1:0] inv_way_ff;
   logic              inv_found;
   logic [LEVELS-1:0] inv_way;
   logic [NP-1:0]     live;

   logic [31:0]        set_wide;
   logic [31:0]        way_wide;
   logic [31:0]        victim_wide;
   logic               stamp_we;
   logic [AW-1:0]      wr_addr;
   logic [STAMP_W-1:0] wr_data;
   logic [WAYS-1:0]    wr_en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         group1_ff    <= G1_RESET;
         cpu_count_ff <= CPUCNT_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_GROUP1_WAYS: group1_ff    <= csr_wdata[G1_W-1:0];
            CSR_CPU_COUNT:   cpu_count_ff <= csr_wdata[CPUCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request word capture
   assign set_wide = 32'(req_set_index);
   assign way_wide = 32'(req_way);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         cpu_ff      <= req_cpu;
         mask_ff     <= req_valid_mask;
         hit_ff      <= req_hit;
         is_write_ff <= req_is_write;
         addr_ff     <= set_wide[AW-1:0];
         set_ok_ff   <= (set_wide < 32'(SETS));
         way_idx_ff  <= way_wide[LEVELS-1:0];
         way_ok_ff   <= (way_wide < 32'(WAYS));
      end
   end

   // way range of the requesting group and first invalid way
   always_comb begin
      logic [5:0] p;
      logic [5:0] lo;
      logic [5:0] hi;
      logic       g1;
      logic [NP-1:0] inv;
      p  = ({1'b0, group1_ff} > WAYS_V) ? WAYS_V : {1'b0, group1_ff};
      g1 = (cpu_count_ff <= 7'd1) || ({1'b0, cpu_ff} < (cpu_count_ff >> 1));
      if (g1) begin
         lo = 6'd0;
         hi = p;
      end else begin
         lo = p;
         hi = WAYS_V;
      end
      if (lo >= hi) begin
         lo = 6'd0;
         hi = WAYS_V;
      end
      for (int i = 0; i < NP; i++) begin
         live[i] = (i < WAYS) && (6'(i) >= lo) && (6'(i) < hi);
         if (i < MASK_W) begin
            inv[i] = live[i] & ~mask_ff[4'(i)];
         end else begin
            inv[i] = 1'b0;
         end
      end
      inv_found = 1'b0;
      inv_way   = '0;
      for (int i = NP - 1; i >= 0; i--) begin
         if (inv[i]) begin
            inv_found = 1'b1;
            inv_way   = LEVELS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         inv_found_ff <= inv_found;
         inv_way_ff   <= inv_way;
      end
   end

   // one tree level per cycle, lower way wins ties
   always_comb begin
      for (int i = 0; i < NP / 2; i++) begin
         if (node_live_ff[2*i+1] &&
             (!node_live_ff[2*i] || node_stamp_ff[2*i+1] < node_stamp_ff[2*i])) begin
            red_stamp[i] = node_stamp_ff[2*i+1];
            red_live[i]  = 1'b1;
            red_way[i]   = node_way_ff[2*i+1];
         end else begin
            red_stamp[i] = node_stamp_ff[2*i];
            red_live[i]  = node_live_ff[2*i];
            red_way[i]   = node_way_ff[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         for (int i = 0; i < NP; i++) begin
            node_stamp_ff[i] <= (i < WAYS && set_ok_ff) ?
                                stamp_mem_ff[addr_ff][LEVELS'(i)] : '0;
            node_live_ff[i]  <= live[i];
            node_way_ff[i]   <= LEVELS'(i);
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < NP / 2; i++) begin
            node_stamp_ff[i] <= red_stamp[i];
            node_live_ff[i]  <= red_live[i];
            node_way_ff[i]   <= red_way[i];
         end
      end
   end

   // stamp writes and clearing pass share the write port
   assign stamp_we = cmd.update && set_ok_ff && way_ok_ff &&
                     ((op_ff == OP_FILL) ||
                      (op_ff == OP_UPDATE && hit_ff && !is_write_ff));

   always_comb begin
      wr_addr = cmd.clear ? clr_addr_ff : addr_ff;
      wr_data = cmd.clear ? '0 : counter_ff;
      for (int w = 0; w < WAYS; w++) begin
         wr_en[w] = cmd.clear || (stamp_we && (way_idx_ff == LEVELS'(w)));
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < WAYS; w++) begin
         if (wr_en[w]) begin
            stamp_mem_ff[wr_addr][w] <= wr_data;
         end
      end
   end

   assign counter_in  = stamp_we ? counter_ff + 64'd1 : counter_ff;
   assign clr_addr_in = cmd.clear ? clr_addr_ff + AW'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         clr_addr_ff <= '0;
      end else begin
         counter_ff  <= counter_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign status.clear_done = (clr_addr_ff == AW'(SETS - 1));

   // result word
   assign victim_wide = 32'(inv_found_ff ? inv_way_ff : node_way_ff[0]);
   assign rsp_victim_way = (op_ff == OP_FIND) ? victim_wide[WAY_W-1:0] : '0;
   assign rsp_victim_was_invalid = (op_ff == OP_FIND) && inv_found_ff;

   `ASSERT_CLK(a_counter_step, clock, reset, !$past(reset) && counter_ff != $past(counter_ff) |-> counter_ff == $past(counter_ff) + 64'd1, "stamp counter moved by other than one")
   `ASSERT_CLK(a_victim_live, clock, reset, cmd.respond && op_ff == OP_FIND |-> node_live_ff[0], "min tree ended on a way outside the range")

endmodule

@@ sv/wplru_ctrl.sv @@
// Controller: sequences clearing pass, row read, tree levels, stamp update and response.
`include "assert_macros.svh"

module wplru_ctrl import wplru_pkg::*; #(
   parameter int WAYS = DEF_WAYS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] req_operation,
   input  dp_status_type   status,
   output dp_cmd_type      cmd,
   output logic            busy,
   output logic            rsp_valid
);

   localparam int LEVELS = $clog2(WAYS);
   localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type        state_ff;
   state_type        state_in;
   logic [LVW-1:0]   lvl_ff;
   logic [LVW-1:0]   lvl_in;
   logic             accept;
   logic             last_lvl;

   assign busy     = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept   = start && !busy;
   assign last_lvl = (lvl_ff == LVW'(LEVELS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               unique case (req_operation)
                  OP_FIND:            state_in = ST_READ;
                  OP_UPDATE, OP_FILL: state_in = ST_UPDATE;
                  default:            state_in = ST_RESP;
               endcase
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ:   state_in = ST_TREE;
         ST_TREE:   if (last_lvl) state_in = ST_RESP;
         ST_UPDATE: state_in = ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear  = 1'b1;
         ST_READ:   cmd.read   = 1'b1;
         ST_TREE:   cmd.reduce = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_RESP: begin
            cmd.respond = 1'b1;
            rsp_valid   = 1'b1;
         end
         default: ;
      endcase
   end

   assign lvl_in = (state_ff == ST_TREE) ? lvl_ff + LVW'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   `ASSERT_CLK(a_no_rsp_after_clear, clock, reset, state_ff == ST_CLEAR |=> !rsp_valid, "response during clearing pass")
   `ASSERT_CLK(a_single_strobe, clock, reset, rsp_valid && !start |=> !rsp_valid, "response strobe held without a new word")

endmodule

@@ sv/way_partitioned_lru_victim_select.sv @@
// Top level of the way-partitioned LRU victim select block.
// Usage:
//   Request channel: a word is taken at a clock edge with start high and busy low;
//   req_operation selects find victim, access update or fill.
//   Response channel: rsp_valid is high for exactly one cycle per request word, with
//   rsp_victim_way and rsp_victim_was_invalid valid in that cycle. The receiver
//   cannot stall; the response is taken at the end of the strobe cycle.
//   CSR channel: csr_ready is always high; index 0 is the partition point, index 1
//   the CPU count. Write only while no request is in flight.
// Sequence per operation:
//   find victim: the row of the stamp memory is read into registers, then the min
//   tree is reduced level by level, then the strobe follows.
//   update and fill: the stamp is written, and the strobe comes in the next cycle.
//   unused operation: strobe in the next cycle.
//   busy drops in the strobe cycle, so the next word can be taken there.
// Reset: the stamp memory is cleared one set per cycle, with busy high;
//   the stamp counter clears to zero and the CSRs return to 8 and 2.
module way_partitioned_lru_victim_select import wplru_pkg::*; #(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [CPU_W-1:0]     req_cpu,
   input  logic [SET_W-1:0]     req_set_index,
   input  logic [WAY_W-1:0]     req_way,
   input  logic [MASK_W-1:0]    req_valid_mask,
   input  logic                 req_is_write,
   input  logic                 req_hit,
   output logic                 rsp_valid,
   output logic [WAY_W-1:0]     rsp_victim_way,
   output logic                 rsp_victim_was_invalid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   wplru_ctrl #(
      .WAYS (WAYS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   wplru_dp #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_operation),
      .req_cpu                (req_cpu),
      .req_set_index          (req_set_index),
      .req_way                (req_way),
      .req_valid_mask         (req_valid_mask),
      .req_is_write           (req_is_write),
      .req_hit                (req_hit),
      .csr_wr                 (csr_valid & csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_victim_way         (rsp_victim_way),
      .rsp_victim_was_invalid (rsp_victim_was_invalid)
   );

endmodule
